// File: design/intel_hex_record_parser_assert.svh
// Assertion macros for the port-level checker of the hex record parser.
`ifndef INTEL_HEX_RECORD_PARSER_ASSERT_SVH
`define INTEL_HEX_RECORD_PARSER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define IHEX_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define IHEX_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/ihex_pkg.sv
// Shared types and constants for the hex record parser.
package ihex_pkg;

  // Result kinds
  localparam logic [2:0] KIND_DATA     = 3'd0;
  localparam logic [2:0] KIND_EOF      = 3'd1;
  localparam logic [2:0] KIND_BADSTART = 3'd2;
  localparam logic [2:0] KIND_BADTYPE  = 3'd3;
  localparam logic [2:0] KIND_WARN     = 3'd4;

  // Record types
  localparam logic [7:0] REC_DATA   = 8'h00;
  localparam logic [7:0] REC_EOF    = 8'h01;
  localparam logic [7:0] REC_EXTLIN = 8'h04;
  localparam logic [7:0] REC_START  = 8'h05;

  // Characters
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;

  typedef enum logic [6:0] {
    PH_START  = 7'b0000001,
    PH_COUNT  = 7'b0000010,
    PH_ADDR   = 7'b0000100,
    PH_TYPE   = 7'b0001000,
    PH_DATA   = 7'b0010000,
    PH_OFFSET = 7'b0100000,
    PH_TAIL   = 7'b1000000
  } phase_t;

  // ASCII hex digit to value; anything else reads as zero.
  function automatic logic [3:0] hex_value(input logic [7:0] c);
    logic [3:0] v;
    case (c) inside
      [8'h30:8'h39]: v = 4'(c - 8'h30);
      [8'h41:8'h46]: v = 4'(c - 8'h37);
      [8'h61:8'h66]: v = 4'(c - 8'h57);
      default:       v = 4'd0;
    endcase
    return v;
  endfunction

endpackage

// File: design/intel_hex_record_parser.sv
// Intel HEX record parser: one text character in, at most one result beat out.
//
//  channel | handshake            | payload
//  --------+----------------------+---------------------------------------------
//  in      | in_valid / in_stall  | in_char
//  out     | out_valid / out_stall| result_kind, write_address, write_data
//  cfg     | cfg_we               | cfg_wdata (flash_base)
//
// One character per cycle while in_stall is low: the parse state updates on
// the accepting edge and any result lands in the output register on the same
// edge, so a result beat is valid in the cycle after its character is accepted.
// in_stall rises only while the output register holds a beat that is stalled.
// rst is synchronous and active high; it clears the parse state, the halt
// flag, flash_base and the output valid.
module intel_hex_record_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_char,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  result_kind,
  output logic [31:0] write_address,
  output logic [7:0]  write_data,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  // Parse state
  ihex_pkg::phase_t phase, phase_next;
  logic [2:0]  digit_count, digit_count_next;
  logic [7:0]  byte_count, byte_count_next;
  logic [15:0] record_address, record_address_next;
  logic [7:0]  record_type, record_type_next;
  logic [15:0] upper_offset, upper_offset_next;
  logic [7:0]  byte_index, byte_index_next;
  logic [3:0]  high_nibble, high_nibble_next;
  logic        halted, halted_next;
  logic [31:0] flash_base;

  // Result of the current character
  logic        emit;
  logic [2:0]  emit_kind;
  logic [31:0] emit_addr;
  logic [7:0]  emit_data;

  logic        in_accept;
  logic [3:0]  d;
  logic        eol;
  logic [7:0]  type_shift;
  logic [7:0]  index_inc;
  logic [31:0] byte_addr;

  // Output register can take a new beat unless it holds one that is stalled.
  assign in_stall  = out_valid & out_stall;
  assign in_accept = in_valid & ~in_stall;

  assign d          = ihex_pkg::hex_value(in_char);
  assign eol        = (in_char == ihex_pkg::CH_CR) || (in_char == ihex_pkg::CH_LF);
  assign type_shift = {record_type[3:0], d};
  assign index_inc  = byte_index + 8'd1;
  // (upper << 16) + address is a plain concatenation
  assign byte_addr  = {upper_offset, record_address} + {24'd0, byte_index} - flash_base;

  always_comb begin
    phase_next          = phase;
    digit_count_next    = digit_count;
    byte_count_next     = byte_count;
    record_address_next = record_address;
    record_type_next    = record_type;
    upper_offset_next   = upper_offset;
    byte_index_next     = byte_index;
    high_nibble_next    = high_nibble;
    halted_next         = halted;
    emit                = 1'b0;
    emit_kind           = ihex_pkg::KIND_DATA;
    emit_addr           = 32'd0;
    emit_data           = 8'd0;

    if (!halted) begin
      case (phase)
        ihex_pkg::PH_COUNT: begin
          byte_count_next = {byte_count[3:0], d};
          if (digit_count == 3'd1) begin
            digit_count_next = 3'd0;
            phase_next       = ihex_pkg::PH_ADDR;
          end else begin
            digit_count_next = digit_count + 3'd1;
          end
        end
        ihex_pkg::PH_ADDR: begin
          record_address_next = {record_address[11:0], d};
          if (digit_count == 3'd3) begin
            digit_count_next = 3'd0;
            phase_next       = ihex_pkg::PH_TYPE;
          end else begin
            digit_count_next = digit_count + 3'd1;
          end
        end
        ihex_pkg::PH_TYPE: begin
          record_type_next = type_shift;
          if (digit_count == 3'd0) begin
            digit_count_next = 3'd1;
          end else begin
            digit_count_next = 3'd0;
            byte_index_next  = 8'd0;
            case (type_shift)
              ihex_pkg::REC_DATA: begin
                phase_next = (byte_count == 8'd0) ? ihex_pkg::PH_TAIL : ihex_pkg::PH_DATA;
              end
              ihex_pkg::REC_EOF, ihex_pkg::REC_START: begin
                phase_next = ihex_pkg::PH_TAIL;
              end
              ihex_pkg::REC_EXTLIN: begin
                upper_offset_next = 16'd0;
                phase_next        = ihex_pkg::PH_OFFSET;
              end
              default: begin
                halted_next = 1'b1;
                emit        = 1'b1;
                emit_kind   = ihex_pkg::KIND_BADTYPE;
              end
            endcase
          end
        end
        ihex_pkg::PH_DATA: begin
          if (digit_count == 3'd0) begin
            high_nibble_next = d;
            digit_count_next = 3'd1;
          end else begin
            digit_count_next = 3'd0;
            byte_index_next  = index_inc;
            if (index_inc == byte_count) begin
              phase_next = ihex_pkg::PH_TAIL;
            end
            emit      = 1'b1;
            emit_kind = ihex_pkg::KIND_DATA;
            emit_addr = byte_addr;
            emit_data = {high_nibble, d};
          end
        end
        ihex_pkg::PH_OFFSET: begin
          upper_offset_next = {upper_offset[11:0], d};
          if (digit_count == 3'd3) begin
            digit_count_next = 3'd0;
            phase_next       = ihex_pkg::PH_TAIL;
          end else begin
            digit_count_next = digit_count + 3'd1;
          end
        end
        ihex_pkg::PH_TAIL: begin
          // checksum and trailing text ignored until line end
          if (eol) begin
            phase_next = ihex_pkg::PH_START;
            if (record_type == ihex_pkg::REC_EOF) begin
              halted_next = 1'b1;
              emit        = 1'b1;
              emit_kind   = ihex_pkg::KIND_EOF;
            end else if (record_type == ihex_pkg::REC_START) begin
              emit      = 1'b1;
              emit_kind = ihex_pkg::KIND_WARN;
            end
          end
        end
        default: begin
          // waiting for ':'; CR/LF skipped, anything else is fatal
          phase_next = ihex_pkg::PH_START;
          if (!eol) begin
            if (in_char != ihex_pkg::CH_COLON) begin
              halted_next = 1'b1;
              emit        = 1'b1;
              emit_kind   = ihex_pkg::KIND_BADSTART;
            end else begin
              digit_count_next    = 3'd0;
              byte_count_next     = 8'd0;
              record_address_next = 16'd0;
              record_type_next    = 8'd0;
              phase_next          = ihex_pkg::PH_COUNT;
            end
          end
        end
      endcase
    end
  end

  // Parse state and config
  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= ihex_pkg::PH_START;
      digit_count    <= 3'd0;
      byte_count     <= 8'd0;
      record_address <= 16'd0;
      record_type    <= 8'd0;
      upper_offset   <= 16'd0;
      byte_index     <= 8'd0;
      high_nibble    <= 4'd0;
      halted         <= 1'b0;
      flash_base     <= 32'd0;
    end else begin
      if (in_accept) begin
        phase          <= phase_next;
        digit_count    <= digit_count_next;
        byte_count     <= byte_count_next;
        record_address <= record_address_next;
        record_type    <= record_type_next;
        upper_offset   <= upper_offset_next;
        byte_index     <= byte_index_next;
        high_nibble    <= high_nibble_next;
        halted         <= halted_next;
      end
      if (cfg_we) begin
        flash_base <= cfg_wdata;
      end
    end
  end

  // Output register: one beat, refilled on the edge it drains
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_accept) begin
      out_valid <= emit;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept && emit) begin
      result_kind   <= emit_kind;
      write_address <= emit_addr;
      write_data    <= emit_data;
    end
  end

endmodule

// File: design/ihex_checker.sv
// Port-level checks for the hex record parser, bound to the top level.
`include "intel_hex_record_parser_assert.svh"

module ihex_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_valid,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [2:0]  result_kind,
  input logic [31:0] write_address,
  input logic [7:0]  write_data
);

  logic        fatal_kind;
  logic        fatal_beat;
  logic        beat_held;
  logic        in_beat;
  logic        non_data;
  logic        zero_meta;
  logic [42:0] out_payload;

  assign fatal_kind  = (result_kind == ihex_pkg::KIND_EOF) ||
                       (result_kind == ihex_pkg::KIND_BADSTART) ||
                       (result_kind == ihex_pkg::KIND_BADTYPE);
  assign fatal_beat  = out_valid && !out_stall && fatal_kind;
  assign beat_held   = out_valid && out_stall;
  assign in_beat     = in_valid && !in_stall;
  assign non_data    = out_valid && (result_kind != ihex_pkg::KIND_DATA);
  assign zero_meta   = (write_address == 32'd0) && (write_data == 8'd0);
  assign out_payload = {result_kind, write_address, write_data};

  // stalled beat holds its payload
  `IHEX_ASSERT_NEXT(a_out_hold, beat_held, out_valid && $stable(out_payload), "stalled beat changed")

  // input back-pressure only from a stalled output beat
  `IHEX_ASSERT_NOW(a_stall_src, in_stall, beat_held, "input stall without a held beat")

  // non-data kinds carry zero address and data
  `IHEX_ASSERT_NOW(a_zero_meta, non_data, zero_meta, "non-data beat with payload")

  // no result beat appears without an input beat behind it
  `IHEX_ASSERT_NEXT(a_no_spurious, !out_valid && !in_beat, !out_valid, "beat without input")

  // after end of file or an error the parser is halted: nothing follows
  `IHEX_ASSERT_NEXT(a_halt_quiet, fatal_beat, !out_valid, "result after halting beat")

endmodule

bind intel_hex_record_parser ihex_checker u_ihex_checker (.*);

// File: tb/ihex_result_checker.sv
// Scoreboard for the hex record parser: tracks parse state and checks every result beat.
`timescale 1ns / 1ps

module ihex_result_checker
  import ihex_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_stall,
  input  logic [7:0]  in_char,
  input  logic        out_valid,
  input  logic        out_stall,
  input  logic [2:0]  result_kind,
  input  logic [31:0] write_address,
  input  logic [7:0]  write_data,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata,
  output int          fail_count,
  output int          results_due,
  output int          beats_checked
);

  typedef struct packed {
    logic [2:0]  kind;
    logic [31:0] addr;
    logic [7:0]  data;
  } parse_result_t;

  parse_result_t pending_results[$];
  parse_result_t want;
  int            errs;

  // shadow parse state
  phase_t      ph;
  logic [2:0]  ndig;
  logic [7:0]  byte_cnt;
  logic [15:0] rec_addr;
  logic [7:0]  rec_type;
  logic [15:0] upper;
  logic [7:0]  byte_idx;
  logic [3:0]  hi_nib;
  logic        stopped;
  logic [31:0] base;

  function automatic logic [3:0] digit_of(input logic [7:0] c);
    if (c >= "0" && c <= "9") return c[3:0];
    if ((c >= "A" && c <= "F") || (c >= "a" && c <= "f")) return c[3:0] + 4'd9;
    return 4'd0;
  endfunction

  task automatic step_parser(input logic [7:0] c);
    logic [3:0]  d;
    logic        eol;
    logic [31:0] addr;
    d   = digit_of(c);
    eol = (c == CH_CR) || (c == CH_LF);
    if (stopped) return;
    case (ph)
      PH_COUNT: begin
        byte_cnt = {byte_cnt[3:0], d};
        ndig = ndig + 3'd1;
        if (ndig >= 3'd2) begin
          ndig = '0;
          ph = PH_ADDR;
        end
      end
      PH_ADDR: begin
        rec_addr = {rec_addr[11:0], d};
        ndig = ndig + 3'd1;
        if (ndig >= 3'd4) begin
          ndig = '0;
          ph = PH_TYPE;
        end
      end
      PH_TYPE: begin
        rec_type = {rec_type[3:0], d};
        ndig = ndig + 3'd1;
        if (ndig >= 3'd2) begin
          ndig = '0;
          byte_idx = '0;
          case (rec_type)
            REC_DATA:         ph = (byte_cnt == 8'd0) ? PH_TAIL : PH_DATA;
            REC_EOF, REC_START: ph = PH_TAIL;
            REC_EXTLIN: begin
              upper = '0;
              ph = PH_OFFSET;
            end
            default: begin
              stopped = 1'b1;
              pending_results.push_back({KIND_BADTYPE, 32'd0, 8'd0});
            end
          endcase
        end
      end
      PH_DATA: begin
        if (ndig == 3'd0) begin
          hi_nib = d;
          ndig = 3'd1;
        end else begin
          addr = {upper, 16'h0000} + {16'h0000, rec_addr} + {24'h0, byte_idx} - base;
          pending_results.push_back({KIND_DATA, addr, {hi_nib, d}});
          ndig = '0;
          byte_idx = byte_idx + 8'd1;
          if (byte_idx == byte_cnt) ph = PH_TAIL;
        end
      end
      PH_OFFSET: begin
        upper = {upper[11:0], d};
        ndig = ndig + 3'd1;
        if (ndig >= 3'd4) begin
          ndig = '0;
          ph = PH_TAIL;
        end
      end
      PH_TAIL: begin
        if (eol) begin
          ph = PH_START;
          if (rec_type == REC_EOF) begin
            stopped = 1'b1;
            pending_results.push_back({KIND_EOF, 32'd0, 8'd0});
          end else if (rec_type == REC_START) begin
            pending_results.push_back({KIND_WARN, 32'd0, 8'd0});
          end
        end
      end
      default: begin
        ph = PH_START;
        if (!eol) begin
          if (c != CH_COLON) begin
            stopped = 1'b1;
            pending_results.push_back({KIND_BADSTART, 32'd0, 8'd0});
          end else begin
            ndig = '0;
            byte_cnt = '0;
            rec_addr = '0;
            rec_type = '0;
            ph = PH_COUNT;
          end
        end
      end
    endcase
  endtask

  always @(posedge clk) begin
    if (rst) begin
      ph = PH_START;
      ndig = '0;
      byte_cnt = '0;
      rec_addr = '0;
      rec_type = '0;
      upper = '0;
      byte_idx = '0;
      hi_nib = '0;
      stopped = 1'b0;
      base = '0;
      pending_results.delete();
      fail_count <= 0;
      beats_checked <= 0;
    end else begin
      // output beat first: it belongs to a character taken on an earlier edge
      if (out_valid && !out_stall) begin
        errs = 0;
        if (pending_results.size() == 0) begin
          $error("unexpected result beat: result_kind %0d, write_address %h, write_data %h",
                 result_kind, write_address, write_data);
          errs = 1;
        end else begin
          want = pending_results.pop_front();
          beats_checked <= beats_checked + 1;
          if (result_kind !== want.kind) begin
            $error("result_kind: expected %0d, got %0d", want.kind, result_kind);
            errs++;
          end
          if (write_address !== want.addr) begin
            $error("write_address: expected %h, got %h", want.addr, write_address);
            errs++;
          end
          if (write_data !== want.data) begin
            $error("write_data: expected %h, got %h", want.data, write_data);
            errs++;
          end
        end
        fail_count <= fail_count + errs;
      end
      if (cfg_we) base = cfg_wdata;
      if (in_valid && !in_stall) step_parser(in_char);
    end
    results_due <= pending_results.size();
  end

endmodule

// File: tb/tb_top.sv
// Top-level testbench of the hex record parser: clock, reset, character stimulus, verdict.
`timescale 1ns / 1ps

module tb_top;
  import ihex_pkg::*;

  localparam int HALF_PERIOD    = 10;
  localparam int RESET_CYCLES   = 11;
  // characters sent by the end of the random phases, directed ones included
  localparam int RANDOM_CHARS   = 1400;
  localparam int NUM_PHASES     = 4;
  // Longest legal quiet stretch is one stall burst or sender gap plus a short
  // drain; this is many times that.
  localparam int WATCHDOG_LIMIT = 2000;

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        in_valid  = 1'b0;
  logic [7:0]  in_char   = 8'h00;
  logic        out_stall = 1'b0;
  logic        cfg_we    = 1'b0;
  logic [31:0] cfg_wdata = 32'h0;

  logic        in_stall;
  logic        out_valid;
  logic [2:0]  result_kind;
  logic [31:0] write_address;
  logic [7:0]  write_data;

  int fail_count;
  int results_due;
  int beats_checked;

  int sent_chars  = 0;
  int base_writes = 0;
  int gap_pct     = 0;   // chance per character that the sender idles first
  int stall_pct   = 0;   // chance per cycle that the receiver starts a stall burst
  int idle_cycles = 0;

  // payload bytes of the record being built
  logic [7:0] line_bytes [256];
  string      end_name;

  always #(HALF_PERIOD) clk = ~clk;

  intel_hex_record_parser i_dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_char       (in_char),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_kind   (result_kind),
    .write_address (write_address),
    .write_data    (write_data),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata)
  );

  ihex_result_checker i_checker (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_char       (in_char),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_kind   (result_kind),
    .write_address (write_address),
    .write_data    (write_data),
    .cfg_we        (cfg_we),
    .cfg_wdata     (cfg_wdata),
    .fail_count    (fail_count),
    .results_due   (results_due),
    .beats_checked (beats_checked)
  );

  // Watchdog: any cycle without a beat on either channel counts toward the limit.
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  // Receiver back-pressure: random stall bursts.
  initial begin
    while (rst) @(posedge clk);
    forever begin
      @(posedge clk);
      if (stall_pct != 0 && $urandom_range(0, 99) < stall_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  function automatic logic is_hex(input logic [7:0] c);
    return (c >= "0" && c <= "9") || (c >= "A" && c <= "F") || (c >= "a" && c <= "f");
  endfunction

  // Any byte that is not a hex digit; CR and LF included, they read as zero
  // in a digit slot.
  function automatic logic [7:0] non_hex_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (is_hex(c)) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // Trailing junk after the checksum: anything but a line end.
  function automatic logic [7:0] tail_char();
    logic [7:0] c;
    c = 8'($urandom_range(0, 255));
    while (c == CH_CR || c == CH_LF) c = 8'($urandom_range(0, 255));
    return c;
  endfunction

  // One character beat. valid stays high between back-to-back characters so
  // it is never lowered and raised in the same step; it drops in a gap or a drain.
  task automatic send_char(input logic [7:0] c);
    if (gap_pct != 0 && $urandom_range(0, 99) < gap_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_char  <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent_chars++;
  endtask

  // Hex digits, most significant first, random letter case; noise_pct of
  // the digits are replaced by a non-hex byte.
  task automatic send_hex(input logic [31:0] value, input int ndig, input int noise_pct);
    logic [3:0] nib;
    logic [7:0] c;
    for (int i = ndig - 1; i >= 0; i--) begin
      nib = value[4*i +: 4];
      if (nib < 4'd10) c = "0" + 8'(nib);
      else c = ($urandom_range(0, 1) ? "a" : "A") + 8'(nib) - 8'd10;
      if (noise_pct != 0 && $urandom_range(0, 99) < noise_pct) c = non_hex_char();
      send_char(c);
    end
  endtask

  task automatic send_eol();
    case ($urandom_range(0, 2))
      0: begin
        send_char(CH_CR);
        send_char(CH_LF);
      end
      1: send_char(CH_LF);
      default: send_char(CH_CR);
    endcase
  endtask

  task automatic fill_line(input int cnt);
    for (int i = 0; i < cnt; i++) line_bytes[i] = 8'($urandom_range(0, 255));
  endtask

  // A well-formed record with payload from line_bytes. Noise goes only into
  // digit slots the parser consumes by position, so the record keeps its shape:
  // address and payload, but not the payload of a start address record, which
  // is read as tail where a CR or LF would end the line.
  task automatic send_record(input logic [7:0] rtype, input logic [7:0] cnt,
                             input logic [15:0] addr, input int noise_pct);
    logic [7:0] sum;
    if ($urandom_range(0, 99) < 15)
      repeat ($urandom_range(1, 3)) send_char($urandom_range(0, 1) ? CH_CR : CH_LF);
    send_char(CH_COLON);
    send_hex(32'(cnt), 2, 0);
    send_hex(32'(addr), 4, noise_pct);
    send_hex(32'(rtype), 2, 0);
    sum = cnt + addr[15:8] + addr[7:0] + rtype;
    for (int i = 0; i < cnt; i++) begin
      send_hex(32'(line_bytes[i]), 2, (rtype == REC_START) ? 0 : noise_pct);
      sum = sum + line_bytes[i];
    end
    send_hex(32'(8'(~sum + 8'd1)), 2, 0);
    if ($urandom_range(0, 9) == 0) repeat ($urandom_range(1, 4)) send_char(tail_char());
    send_eol();
  endtask

  // Data record cut short: the line break lands in a data slot (one 0x00
  // byte), and junk bytes fill the missing digits before the real line end.
  task automatic send_torn(input int cnt, input int kept, input logic [15:0] addr);
    int junk = 2 * (cnt - kept) - 2;
    send_char(CH_COLON);
    send_hex(cnt, 2, 0);
    send_hex(32'(addr), 4, 0);
    send_hex(32'(REC_DATA), 2, 0);
    for (int i = 0; i < kept; i++) send_hex(32'(line_bytes[i]), 2, 0);
    send_char(CH_CR);
    send_char(CH_LF);
    repeat (junk) send_char(8'($urandom_range(0, 255)));
    send_eol();
  endtask

  // Hold the sender off until every predicted result beat is out, then allow
  // for the output register.
  task automatic wait_results_drained();
    in_valid <= 1'b0;
    @(posedge clk);
    while (results_due != 0) @(posedge clk);
    repeat (3) @(posedge clk);
  endtask

  task automatic set_flash_base(input logic [31:0] value);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
    base_writes++;
  endtask

  task automatic pick_idle_rates();
    case ($urandom_range(0, 3))
      0: begin gap_pct = 0;  stall_pct = 0;  end
      1: begin gap_pct = 5;  stall_pct = 5;  end
      2: begin gap_pct = 20; stall_pct = 10; end
      default: begin gap_pct = 10; stall_pct = 30; end
    endcase
  endtask

  // Mostly data and offset records, plus warnings, empty records and torn lines.
  task automatic send_random_record();
    int          pick;
    int          cnt;
    int          noise;
    logic [15:0] addr;
    pick  = $urandom_range(0, 99);
    noise = ($urandom_range(0, 9) < 3) ? 10 : 0;
    if ($urandom_range(0, 9) == 0) addr = 16'hFFFF - 16'($urandom_range(0, 15));
    else addr = 16'($urandom_range(0, 65535));
    if (pick < 62) begin
      // a full 255-byte record now and then, short ones otherwise
      cnt = ($urandom_range(0, 59) == 0) ? 255 : $urandom_range(1, 16);
      fill_line(cnt);
      send_record(REC_DATA, 8'(cnt), addr, noise);
    end else if (pick < 72) begin
      case ($urandom_range(0, 3))
        0: begin line_bytes[0] = 8'hFF; line_bytes[1] = 8'hFF; end
        1: begin line_bytes[0] = 8'h00; line_bytes[1] = 8'h00; end
        default: fill_line(2);
      endcase
      send_record(REC_EXTLIN, 8'd2, 16'h0000, noise);
    end else if (pick < 78) begin
      fill_line(4);
      send_record(REC_START, 8'd4, addr, noise);
    end else if (pick < 83) begin
      send_record(REC_DATA, 8'd0, addr, noise);
    end else begin
      cnt = $urandom_range(2, 12);
      fill_line(cnt);
      send_torn(cnt, $urandom_range(0, cnt - 1), addr);
    end
  endtask

  initial begin
    int          stop_at;
    logic [31:0] next_base;
    logic [7:0]  bad_type;
    logic [7:0]  bad_start;

    repeat (RESET_CYCLES) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    set_flash_base(32'h0000_0000);

    // Directed: empty data record, byte extremes, offset FFFF with a record
    // that crosses the 4 GB wrap, start address warning, offset back to zero,
    // non-hex digits read as zero, a line break inside the data field.
    send_record(REC_DATA, 8'd0, 16'h1234, 0);
    line_bytes[0] = 8'h00;
    line_bytes[1] = 8'hFF;
    line_bytes[2] = 8'h5A;
    line_bytes[3] = 8'hA5;
    send_record(REC_DATA, 8'd4, 16'h0000, 0);
    line_bytes[0] = 8'hFF;
    line_bytes[1] = 8'hFF;
    send_record(REC_EXTLIN, 8'd2, 16'h0000, 0);
    fill_line(4);
    send_record(REC_DATA, 8'd4, 16'hFFFE, 0);
    fill_line(4);
    send_record(REC_START, 8'd4, 16'h0000, 0);
    line_bytes[0] = 8'h00;
    line_bytes[1] = 8'h00;
    send_record(REC_EXTLIN, 8'd2, 16'h0000, 0);
    fill_line(3);
    send_record(REC_DATA, 8'd3, 16'hBEEF, 50);
    fill_line(3);
    send_torn(3, 1, 16'h0100);
    wait_results_drained();

    // Random phases, each under its own flash_base; the last runs with no
    // idling on either side.
    for (int p = 0; p < NUM_PHASES; p++) begin
      case (p)
        0: next_base = 32'hFFFF_FFFF;
        1: next_base = $urandom();
        2: next_base = $urandom() & 32'hFFFF_0000;
        default: next_base = $urandom();
      endcase
      set_flash_base(next_base);
      if (p == NUM_PHASES - 1) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        pick_idle_rates();
      end
      stop_at = (RANDOM_CHARS * (p + 1)) / NUM_PHASES;
      while (sent_chars < stop_at) begin
        if (p != NUM_PHASES - 1) begin
          if ($urandom_range(0, 9) == 0) pick_idle_rates();
          if ($urandom_range(0, 29) == 0) wait_results_drained();
        end
        send_random_record();
      end
      wait_results_drained();
    end

    // The parser halts for good on end of file, a bad type or a bad start
    // code, and reset comes only once, so one of the three closes the run.
    case ($urandom_range(0, 2))
      0: begin
        end_name = "end of file record";
        send_record(REC_EOF, 8'd0, 16'h0000, 0);
      end
      1: begin
        end_name = "unknown record type";
        bad_type = 8'($urandom_range(0, 255));
        while (bad_type == REC_DATA || bad_type == REC_EOF ||
               bad_type == REC_EXTLIN || bad_type == REC_START)
          bad_type = 8'($urandom_range(0, 255));
        send_record(bad_type, 8'd0, 16'($urandom_range(0, 65535)), 0);
      end
      default: begin
        end_name = "missing start code";
        bad_start = 8'($urandom_range(0, 255));
        while (bad_start == CH_CR || bad_start == CH_LF || bad_start == CH_COLON)
          bad_start = 8'($urandom_range(0, 255));
        send_char(bad_start);
      end
    endcase
    // halted: these must not produce any beat
    fill_line(8);
    send_record(REC_DATA, 8'd8, 16'h0000, 0);
    repeat (8) send_char(8'($urandom_range(0, 255)));

    wait_results_drained();
    repeat (8) @(posedge clk);

    $display("Run covered %0d characters under %0d flash_base settings, %0d result beats checked.",
             sent_chars, base_writes, beats_checked);
    $display("Parser stopped on a %s; trailing characters ignored.", end_name);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
